// ===== src/abkf_pkg.sv =====
// Package for the angle/bias Kalman filter core: command codes, constants
// and the saturation and rounding helpers. No dependencies.
package abkf_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd3;

    localparam logic [30:0] RESET_ANGLE_NOISE = 31'd16777;
    localparam logic [30:0] RESET_BIAS_NOISE = 31'd50332;
    localparam logic [30:0] RESET_MEAS_NOISE = 31'd8388608;
    localparam logic [24:0] RESET_PERIOD = 25'd83886;
    localparam logic signed [31:0] ONE_Q24 = 32'sd16777216;

    // Datapath step codes
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_ANGLE = 4'd0;  // angle += (gyro-bias)*dt
    localparam logic [OP_W-1:0] OP_P00 = 4'd1;
    localparam logic [OP_W-1:0] OP_P01 = 4'd2;    // P01 and P10 share product
    localparam logic [OP_W-1:0] OP_P11 = 4'd3;
    localparam logic [OP_W-1:0] OP_DIV0 = 4'd4;   // start k0 division
    localparam logic [OP_W-1:0] OP_DIV1 = 4'd5;   // start k1 division
    localparam logic [OP_W-1:0] OP_C00 = 4'd6;
    localparam logic [OP_W-1:0] OP_C01 = 4'd7;
    localparam logic [OP_W-1:0] OP_C10 = 4'd8;
    localparam logic [OP_W-1:0] OP_C11 = 4'd9;
    localparam logic [OP_W-1:0] OP_CANG = 4'd10;
    localparam logic [OP_W-1:0] OP_CBIAS = 4'd11;
    localparam logic [OP_W-1:0] OP_OUT = 4'd12;

    typedef struct packed {
        logic           load;   // capture input item
        logic           step;   // perform step op
        logic [OP_W-1:0] op;
    } abkf_cmd_t;

    typedef struct packed {
        logic div_busy;
    } abkf_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
        else if (v < -66'sd2147483648) return 32'sh80000000;
        else return v[31:0];
    endfunction

    // v * 2^-24 rounded to nearest, ties up (arithmetic shift floors)
    function automatic logic signed [65:0] rescale24(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = v + 66'sd8388608;
        return t >>> 24;
    endfunction

endpackage

// ===== src/abkf_div.sv =====
// Restoring divider: 56-bit magnitude numerator by 33-bit magnitude, one
// quotient bit per cycle. Uses abkf_pkg.
module abkf_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [31:0]  num,     // numerator before * 2^24
    input  logic signed [32:0]  den,     // nonzero
    output logic                busy,
    output logic signed [31:0]  quot     // saturated, toward zero
);
    import abkf_pkg::*;

    logic [5:0]  cnt_reg, cnt_next;
    logic [55:0] n_reg, n_next;
    logic [55:0] q_reg, q_next;
    logic [32:0] d_reg, d_next;
    logic [33:0] r_reg, r_next;
    logic        neg_reg, neg_next;
    logic [33:0] trial;
    logic [55:0] qmag;
    logic signed [65:0] qs;

    always_comb begin
        cnt_next = cnt_reg;
        n_next = n_reg;
        q_next = q_reg;
        d_next = d_reg;
        r_next = r_reg;
        neg_next = neg_reg;
        trial = {r_reg[32:0], n_reg[55]} - {1'b0, d_reg};
        if (start) begin
            n_next = {(num[31] ? 32'(-num) : 32'(num)), 24'd0};
            d_next = den[32] ? 33'(-den) : 33'(den);
            neg_next = num[31] ^ den[32];
            r_next = '0;
            q_next = '0;
            cnt_next = 6'd56;
        end else if (cnt_reg != 6'd0) begin
            n_next = {n_reg[54:0], 1'b0};
            if (!trial[33]) begin
                r_next = trial;
                q_next = {q_reg[54:0], 1'b1};
            end else begin
                r_next = {r_reg[32:0], n_reg[55]};
                q_next = {q_reg[54:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        n_reg <= n_next;
        q_reg <= q_next;
        d_reg <= d_next;
        r_reg <= r_next;
        neg_reg <= neg_next;
    end

    assign busy = start || (cnt_reg != 6'd0);
    assign qmag = q_reg;
    assign qs = neg_reg ? -$signed({10'd0, qmag}) : $signed({10'd0, qmag});
    assign quot = sat32(qs);
endmodule

// ===== src/abkf_datapath.sv =====
// Filter datapath: state and covariance registers, one shared combinational
// multiplier and the gain divider. Uses abkf_pkg, abkf_div.
module abkf_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  abkf_pkg::abkf_cmd_t   cmd,
    output abkf_pkg::abkf_stat_t  stat,
    input  logic signed [24:0]    s_meas,
    input  logic signed [27:0]    s_gyro,
    input  logic [30:0]           q_angle,
    input  logic [30:0]           q_bias,
    input  logic [30:0]           r_meas,
    input  logic [24:0]           dt,
    output logic signed [31:0]    angle_out,
    output logic signed [31:0]    rate_out
);
    import abkf_pkg::*;

    logic signed [31:0] ang_reg, bias_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] k0_reg, k1_reg, err_reg, t0_reg, t1_reg;
    logic signed [24:0] meas_reg;
    logic signed [27:0] gyro_reg;
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [65:0] prod, rs;
    logic               div_start;
    logic signed [31:0] div_num;
    logic signed [32:0] den;
    logic signed [31:0] quot;
    logic               div_busy;
    logic               den_zero;

    assign den = $signed({2'b0, r_meas}) + 33'(p00_reg);
    assign den_zero = (den == 33'sd0);

    // operand selection for the single multiplier
    always_comb begin
        mul_a = '0;
        mul_b = $signed({9'd0, dt});
        case (cmd.op)
            OP_ANGLE: mul_a = 34'(gyro_reg) - 34'(bias_reg);
            OP_P00:   mul_a = $signed({3'b0, q_angle}) - 34'(p01_reg) - 34'(p10_reg);
            OP_P01:   mul_a = -34'(p11_reg);
            OP_P11:   mul_a = $signed({3'b0, q_bias});
            OP_C00:   begin mul_a = 34'(k0_reg); mul_b = 34'(t0_reg); end
            OP_C01:   begin mul_a = 34'(k0_reg); mul_b = 34'(t1_reg); end
            OP_C10:   begin mul_a = 34'(k1_reg); mul_b = 34'(t0_reg); end
            OP_C11:   begin mul_a = 34'(k1_reg); mul_b = 34'(t1_reg); end
            OP_CANG:  begin mul_a = 34'(k0_reg); mul_b = 34'(err_reg); end
            OP_CBIAS: begin mul_a = 34'(k1_reg); mul_b = 34'(err_reg); end
            default:  mul_a = '0;
        endcase
    end

    assign prod = 66'(mul_a) * 66'(mul_b);
    assign rs = rescale24(prod);

    assign div_start = cmd.step && !den_zero && (cmd.op == OP_DIV0 || cmd.op == OP_DIV1);
    assign div_num = (cmd.op == OP_DIV0) ? p00_reg : p10_reg;

    abkf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (den),
        .busy    (div_busy),
        .quot    (quot)
    );

    assign stat.div_busy = div_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ang_reg <= '0;
            bias_reg <= '0;
            p00_reg <= ONE_Q24;
            p01_reg <= '0;
            p10_reg <= '0;
            p11_reg <= ONE_Q24;
            k0_reg <= '0;
            k1_reg <= '0;
        end else if (cmd.load) begin
            meas_reg <= s_meas;
            gyro_reg <= s_gyro;
        end else if (cmd.step) begin
            case (cmd.op)
                OP_ANGLE: ang_reg <= sat32(66'(ang_reg) + rs);
                OP_P00:   p00_reg <= sat32(66'(p00_reg) + rs);
                OP_P01: begin
                    p01_reg <= sat32(66'(p01_reg) + rs);
                    p10_reg <= sat32(66'(p10_reg) + rs);
                end
                OP_P11: begin
                    p11_reg <= sat32(66'(p11_reg) + rs);
                    err_reg <= sat32(66'(meas_reg) - 66'(ang_reg));
                end
                OP_DIV0: begin
                    if (den_zero) begin
                        k0_reg <= '0;
                        k1_reg <= '0;
                    end
                    t0_reg <= p00_reg;
                    t1_reg <= p01_reg;
                end
                OP_DIV1: begin
                    if (!den_zero) k0_reg <= quot;
                end
                OP_C00: begin
                    if (!den_zero) k1_reg <= quot;
                    p00_reg <= sat32(66'(p00_reg) - rs);
                end
                OP_C01: p01_reg <= sat32(66'(p01_reg) - rs);
                OP_C10: p10_reg <= sat32(66'(p10_reg) - rs);
                OP_C11: p11_reg <= sat32(66'(p11_reg) - rs);
                OP_CANG: ang_reg <= sat32(66'(ang_reg) + rs);
                OP_CBIAS: bias_reg <= sat32(66'(bias_reg) + rs);
                default: ;
            endcase
        end
    end

    assign angle_out = ang_reg;
    assign rate_out = sat32(66'(gyro_reg) - 66'(bias_reg));
endmodule

// ===== src/abkf_ctrl.sv =====
// Sequencer for the filter: walks the datapath through one sample and runs
// the output handshake. Uses abkf_pkg.
module abkf_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic                  cap_out,
    output abkf_pkg::abkf_cmd_t   cmd,
    input  abkf_pkg::abkf_stat_t  stat
);
    import abkf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]      state_reg, state_next;
    logic [OP_W-1:0] op_reg, op_next;
    logic            ov_reg, ov_next;
    logic            fire;

    // the output register frees as soon as it is taken
    assign s_tready = (state_reg == ST_IDLE) && (!ov_reg || m_tready);
    assign fire = s_tvalid && s_tready;
    assign m_tvalid = ov_reg;

    always_comb begin
        state_next = state_reg;
        op_next = op_reg;
        ov_next = ov_reg && !m_tready;
        cmd.load = 1'b0;
        cmd.step = 1'b0;
        cmd.op = op_reg;
        cap_out = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (fire) begin
                    cmd.load = 1'b1;
                    op_next = OP_ANGLE;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.step = 1'b1;
                if (op_reg == OP_DIV0 || op_reg == OP_DIV1) begin
                    state_next = ST_WAIT;
                    op_next = op_reg + 4'd1;
                end else if (op_reg == OP_OUT) begin
                    cap_out = 1'b1;
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    op_next = op_reg + 4'd1;
                end
            end
            ST_WAIT: begin
                if (!stat.div_busy) state_next = ST_RUN;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg <= OP_ANGLE;
            ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg <= op_next;
            ov_reg <= ov_next;
        end
    end
endmodule

// ===== src/angle_bias_kalman_filter_core.sv =====
// Top level of the two-state angle/gyro-bias Kalman filter.
// Depends on abkf_pkg, abkf_ctrl, abkf_datapath, abkf_div.
//
//  channel | direction | payload
//  s_      | in        | tdata: measured_angle[24:0], gyro_rate[52:25]
//  m_      | out       | tdata: angle_estimate[31:0], rate_estimate[63:32]
//  cfg_    | in        | write enable, index 0..3, 31-bit data
//
// After acceptance a transaction runs ten multiply steps on the shared
// multiplier, two gain steps that each wait on the restoring divider, and
// one output step before its result is valid.
// Reset is synchronous, active low; it restores config, filter and control state.
// A finished result sits in the output register; the next transaction is
// taken in the cycle that result is taken, or at once if it is gone.
module angle_bias_kalman_filter_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [55:0]                       s_tdata,  // measured_angle, gyro_rate
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [63:0]                       m_tdata,  // angle_estimate, rate_estimate
    input  logic                              cfg_we,
    input  logic [abkf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [abkf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import abkf_pkg::*;

    logic [30:0] q_angle_reg, q_bias_reg, r_meas_reg;
    logic [24:0] dt_reg;
    logic [63:0] out_reg;
    logic        cap_out;
    abkf_cmd_t   cmd;
    abkf_stat_t  stat;
    logic signed [31:0] angle_v, rate_v;

    // configuration writes: hold the value until rewritten
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_angle_reg <= RESET_ANGLE_NOISE;
            q_bias_reg <= RESET_BIAS_NOISE;
            r_meas_reg <= RESET_MEAS_NOISE;
            dt_reg <= RESET_PERIOD;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ANGLE_NOISE: q_angle_reg <= cfg_wdata;
                REG_BIAS_NOISE:  q_bias_reg <= cfg_wdata;
                REG_MEAS_NOISE:  r_meas_reg <= cfg_wdata;
                REG_PERIOD:      dt_reg <= cfg_wdata[24:0];
                default: ;
            endcase
        end
    end

    abkf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cap_out  (cap_out),
        .cmd      (cmd),
        .stat     (stat)
    );

    abkf_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_meas    (s_tdata[24:0]),
        .s_gyro    (s_tdata[52:25]),
        .q_angle   (q_angle_reg),
        .q_bias    (q_bias_reg),
        .r_meas    (r_meas_reg),
        .dt        (dt_reg),
        .angle_out (angle_v),
        .rate_out  (rate_v)
    );

    // capture the result in the cycle the output goes valid; the bias update
    // has landed by then
    logic cap_d_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) cap_d_reg <= 1'b0;
        else cap_d_reg <= cap_out;
        if (cap_d_reg) out_reg <= {rate_v, angle_v};
    end

    assign m_tdata = cap_d_reg ? {rate_v, angle_v} : out_reg;
endmodule
